// ----- hdl/rrt_pkg.sv -----
// Package for the nearest-node search and steer block.
// Holds widths, reset constants, status codes and the sequencer state type.
package rrt_pkg;
    localparam int MAX_NODES_DEF  = 1024;
    localparam int COORD_BITS_DEF = 16;
    localparam int STEP_BITS      = 15;
    localparam int IDX_BITS       = $clog2(MAX_NODES_DEF);
    localparam logic [STEP_BITS-1:0] STEP_RESET = 15'd256;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic OP_ROOT = 1'b0;
    localparam logic OP_GROW = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_LAST, S_FETCH, S_SQRT, S_DIVX, S_DIVY, S_SAT, S_OUT
    } t_state;
endpackage

// ----- hdl/rrt_if.sv -----
// Valid/ready channel interfaces for the block.
// Uses rrt_pkg for the coordinate, index and step widths.
interface rrt_in_if import rrt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [COORD_BITS_DEF-1:0] sample_x;
    logic [COORD_BITS_DEF-1:0] sample_y;
    modport source (output valid, opcode, sample_x, sample_y, input ready);
    modport sink (input valid, opcode, sample_x, sample_y, output ready);
endinterface

interface rrt_out_if import rrt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [COORD_BITS_DEF-1:0] new_x;
    logic [COORD_BITS_DEF-1:0] new_y;
    logic [IDX_BITS-1:0]       new_index;
    logic [IDX_BITS-1:0]       parent_index;
    logic [1:0]                status;
    modport source (output valid, new_x, new_y, new_index, parent_index, status,
                    input ready);
    modport sink (input valid, new_x, new_y, new_index, parent_index, status,
                  output ready);
endinterface

interface rrt_cfg_if import rrt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STEP_BITS-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- hdl/rrt_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module rrt_div #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_quo, n_quo;
    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    w_sh;

    always_comb begin
        w_sh  = {r_rem[W-1:0], r_quo[W-1]};
        n_quo = {r_quo[W-2:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem    = w_sh - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_quo;
endmodule

// ----- hdl/rrt_nearest_and_steer.sv -----
// Top level: node memories, nearest-node scan and steer sequencer.
// Depends on rrt_pkg, the channel interfaces and rrt_div.
//
// Channel  Dir  Payload
// in_ch    in   opcode, sample_x, sample_y
// out_ch   out  new_x, new_y, new_index, parent_index, status
// cfg_ch   in   step_length
//
// A grow item takes one memory read per stored node, a 26-step square root and
// two 59-step serial divisions. Root items and rejected grows skip the scan and
// the steer sequence, and are answered from the idle state.
// No clearing pass after reset; only entries below the node count are read.
// The result register holds while out_ch.ready is low and blocks new items.
module rrt_nearest_and_steer
    import rrt_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    rrt_in_if.sink    in_ch,
    rrt_out_if.source out_ch,
    rrt_cfg_if.sink   cfg_ch
);
    localparam int MAX_NODES  = MAX_NODES_DEF;
    localparam int COORD_BITS = COORD_BITS_DEF;
    localparam int AW = IDX_BITS;
    localparam int CNTW = AW + 1;
    localparam int DW = COORD_BITS + 1;
    localparam int D2W = 2 * DW + 1;
    localparam int LW = D2W / 2 + 9;
    localparam int QW = 2 * COORD_BITS + STEP_BITS + 12;
    localparam int PW = STEP_BITS + DW;
    localparam logic signed [DW:0] CMAX = (DW+1)'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [DW:0] CMIN = -CMAX - 1;

    logic [COORD_BITS-1:0] mem_x [MAX_NODES];
    logic [COORD_BITS-1:0] mem_y [MAX_NODES];

    t_state r_state, n_state;
    logic [STEP_BITS-1:0]  r_step;
    logic [CNTW-1:0]       r_count;
    logic signed [COORD_BITS-1:0] r_sx, r_sy;
    logic [AW-1:0]         r_raddr, r_rd_idx, r_best;
    logic                  r_rd_vld, r_first;
    logic [COORD_BITS-1:0] r_qx, r_qy;
    logic [COORD_BITS-1:0] r_bx, r_by;
    logic [D2W-1:0]        r_bd2;
    logic signed [DW-1:0]  r_dx, r_dy;
    logic signed [COORD_BITS-1:0] r_nx, r_ny;
    logic [2*LW-1:0]       r_sv;
    logic [2*LW-1:0]       r_sr;
    logic [2*LW-1:0]       r_sb;
    logic [QW-1:0]         r_qxo;
    logic                  r_wr;
    logic                  r_ov;
    logic [COORD_BITS-1:0] r_ox, r_oy;
    logic [AW-1:0]         r_oi, r_op;
    logic [1:0]            r_os;

    logic                  w_in_acc, w_out_acc, w_dstart, w_ddone;
    logic [QW-1:0]         w_num, w_den, w_quo;
    logic signed [DW-1:0]  w_ex, w_ey;
    logic [D2W-1:0]        w_d2;
    logic [DW-1:0]         w_mag;
    logic [PW-1:0]         w_prod;

    assign in_ch.ready  = (r_state == S_IDLE) && !r_ov;
    assign cfg_ch.ready = 1'b1;
    assign w_in_acc     = in_ch.valid && in_ch.ready;
    assign w_out_acc    = out_ch.valid && out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (r_wr) begin
            mem_x[r_count[AW-1:0]] <= r_nx;
            mem_y[r_count[AW-1:0]] <= r_ny;
        end else if (w_in_acc && in_ch.opcode == OP_ROOT) begin
            mem_x[0] <= in_ch.sample_x;
            mem_y[0] <= in_ch.sample_y;
        end
        r_qx <= mem_x[r_raddr];
        r_qy <= mem_y[r_raddr];
    end

    assign w_ex  = DW'(r_sx) - DW'($signed(r_qx));
    assign w_ey  = DW'(r_sy) - DW'($signed(r_qy));
    assign w_d2  = D2W'(w_ex * w_ex) + D2W'(w_ey * w_ey);
    assign w_mag = (r_state == S_SQRT) ? (r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx))
                                       : (r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy));
    assign w_prod = r_step * w_mag;
    assign w_num = QW'({w_prod, 9'b0}) + QW'(r_sr);
    assign w_den = QW'(r_sr) << 1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc && in_ch.opcode == OP_GROW && r_count != '0
                         && r_count < CNTW'(MAX_NODES)) n_state = S_SCAN;
            S_SCAN:  if (r_raddr == AW'(r_count - 1'b1)) n_state = S_LAST;
            S_LAST:  n_state = S_FETCH;
            S_FETCH: n_state = S_SQRT;
            S_SQRT:  if (r_sb == '0) n_state = S_DIVX;
            S_DIVX:  if (w_ddone) n_state = S_DIVY;
            S_DIVY:  if (w_ddone) n_state = S_SAT;
            S_SAT:   n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign w_dstart = (r_state == S_SQRT && r_sb == '0) || (r_state == S_DIVX && w_ddone);

    rrt_div #(.W(QW)) u_div (
        .i_clk, .i_rst_n, .i_start(w_dstart), .i_num(w_num), .i_den(w_den),
        .o_done(w_ddone), .o_quo(w_quo)
    );

    function automatic logic signed [COORD_BITS-1:0] sat_add(
        input logic [COORD_BITS-1:0] base, input logic signed [DW-1:0] d,
        input logic [QW-1:0] q);
        logic signed [DW:0] s;
        logic [QW-1:0] qq;
        qq = (d == '0 || q > QW'(1 << COORD_BITS)) ?
             ((d == '0) ? '0 : QW'(1 << COORD_BITS)) : q;
        s = (DW+1)'($signed(base)) + (d[DW-1] ? -(DW+1)'(qq) : (DW+1)'(qq));
        if (s > CMAX) s = CMAX;
        if (s < CMIN) s = CMIN;
        return COORD_BITS'(s);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_RESET;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_wr    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wr    <= 1'b0;
            if (cfg_ch.valid) r_step <= cfg_ch.data;
            if (w_out_acc) r_ov <= 1'b0;
            r_rd_vld <= (r_state == S_SCAN);
            r_rd_idx <= r_raddr;
            if (r_rd_vld) begin
                r_first <= 1'b0;
                if (r_first || w_d2 < r_bd2) begin
                    r_bd2  <= w_d2;
                    r_best <= r_rd_idx;
                    r_bx   <= r_qx;
                    r_by   <= r_qy;
                end
            end
            unique case (r_state)
                S_IDLE: if (w_in_acc) begin
                    r_sx <= in_ch.sample_x;
                    r_sy <= in_ch.sample_y;
                    r_raddr <= '0;
                    r_first <= 1'b1;
                    if (in_ch.opcode == OP_ROOT) begin
                        r_count <= CNTW'(1);
                        r_ov <= 1'b1;
                        r_ox <= in_ch.sample_x;
                        r_oy <= in_ch.sample_y;
                        r_oi <= '0;
                        r_op <= '0;
                        r_os <= ST_OK;
                    end else if (r_count == '0 || r_count >= CNTW'(MAX_NODES)) begin
                        r_ov <= 1'b1;
                        r_ox <= '0;
                        r_oy <= '0;
                        r_oi <= '0;
                        r_op <= '0;
                        r_os <= (r_count == '0) ? ST_EMPTY : ST_FULL;
                    end
                end
                S_SCAN: if (r_raddr != AW'(r_count - 1'b1)) r_raddr <= r_raddr + 1'b1;
                S_FETCH: begin
                    r_dx <= DW'(r_sx) - DW'($signed(r_bx));
                    r_dy <= DW'(r_sy) - DW'($signed(r_by));
                    r_sv <= (2*LW)'(r_bd2) << 16;
                    r_sr <= '0;
                    r_sb <= (2*LW)'(1) << (2*LW - 2);
                end
                S_SQRT: if (r_sb != '0) begin
                    if (r_sv >= r_sr + r_sb) begin
                        r_sv <= r_sv - (r_sr + r_sb);
                        r_sr <= (r_sr >> 1) + r_sb;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sb <= r_sb >> 2;
                end
                S_DIVX: if (w_ddone) r_qxo <= w_quo;
                S_DIVY: if (w_ddone) begin
                    r_nx <= sat_add(r_bx, r_dx, (r_sr == '0) ? '0 : r_qxo);
                    r_ny <= sat_add(r_by, r_dy, (r_sr == '0) ? '0 : w_quo);
                end
                S_SAT: begin
                    r_wr <= 1'b1;
                    r_ov <= 1'b1;
                    r_ox <= r_nx;
                    r_oy <= r_ny;
                    r_oi <= r_count[AW-1:0];
                    r_op <= r_best;
                    r_os <= ST_OK;
                end
                S_OUT: r_count <= r_count + 1'b1;
                default: ;
            endcase
        end
    end

    assign out_ch.valid        = r_ov;
    assign out_ch.new_x        = r_ox;
    assign out_ch.new_y        = r_oy;
    assign out_ch.new_index    = r_oi;
    assign out_ch.parent_index = r_op;
    assign out_ch.status       = r_os;

    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !in_ch.ready) else $error("item accepted while busy");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_NODES)) else $error("node count overflow");
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr |-> r_ov) else $error("store without result");
endmodule
